// ----- sv/psimd_pkg.sv -----
// package: operation codes and payload types for the packed integer simd alu
package psimd_pkg;

   typedef enum logic [5:0] {
      OP_AND = 6'd0, OP_ANDN = 6'd1, OP_OR = 6'd2, OP_XOR = 6'd3, OP_PSHUFB = 6'd4,
      OP_PTEST = 6'd5, OP_PCMPEQB = 6'd6, OP_PCMPEQW = 6'd7, OP_PCMPEQD = 6'd8,
      OP_PCMPEQQ = 6'd9, OP_PCMPGTB = 6'd10, OP_PCMPGTW = 6'd11, OP_PCMPGTD = 6'd12,
      OP_PMINUB = 6'd13, OP_PMAXUB = 6'd14, OP_PADDB = 6'd15, OP_PADDW = 6'd16,
      OP_PADDD = 6'd17, OP_PADDQ = 6'd18, OP_PSUBB = 6'd19, OP_PSUBW = 6'd20,
      OP_PSUBD = 6'd21, OP_PSUBQ = 6'd22, OP_PUNPCKLBW = 6'd23, OP_PUNPCKLWD = 6'd24,
      OP_PUNPCKLDQ = 6'd25, OP_PUNPCKLQDQ = 6'd26, OP_PUNPCKHQDQ = 6'd27,
      OP_UNPCKLPS = 6'd28, OP_UNPCKLPD = 6'd29, OP_PSHUFD = 6'd30, OP_PSHUFLW = 6'd31,
      OP_PSHUFHW = 6'd32, OP_SHUFPS = 6'd33, OP_SHUFPD = 6'd34, OP_PSRLW = 6'd35,
      OP_PSRAW = 6'd36, OP_PSLLW = 6'd37, OP_PSRLD = 6'd38, OP_PSRAD = 6'd39,
      OP_PSLLD = 6'd40, OP_PSRLQ = 6'd41, OP_PSLLQ = 6'd42, OP_PSLLDQ = 6'd43,
      OP_PSRLDQ = 6'd44, OP_PMOVMSKB = 6'd45, OP_MOVMSKPS = 6'd46, OP_MOVMSKPD = 6'd47
   } op_type;

   typedef struct packed {
      logic [5:0]  action;
      logic [63:0] dest_low;
      logic [63:0] dest_high;
      logic [63:0] source_low;
      logic [63:0] source_high;
      logic [7:0]  immediate;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
      logic [15:0] sign_mask;
      logic        zero_flag;
      logic        carry_flag;
      logic        supported;
   } rsp_type;

endpackage

// ----- sv/psimd_if.sv -----
// interfaces: valid/ready channels for requests and responses
interface psimd_req_if;
   import psimd_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface psimd_rsp_if;
   import psimd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/packed_integer_simd_alu.sv -----
// top level: packed integer simd alu with input and result registers
// usage:
//   req carries one instruction per transfer: action code, 128-bit destination
//   and source operands split in low and high halves, and an immediate byte.
//   rsp carries one result per request: 128-bit result, movmsk sign mask,
//   ptest zero and carry flags and a supported bit for unknown action codes.
//   a request goes through the input register, then the result register.
//   throughput: one instruction per cycle while rsp is ready; the input and
//   result registers each advance when the next stage is empty or drains.
//   the execute logic between them is a single pass of lane-wise adders,
//   compares, shifters and byte muxes.
//   when the receiver stalls, results hold on rsp and the pipeline fills;
//   req_ready drops once both registers hold items, with no item lost.
//   reset (synchronous, active high) empties both stages; no other state.
module packed_integer_simd_alu (
   input logic clock,
   input logic reset,
   psimd_req_if.sink   req,
   psimd_rsp_if.source rsp
);
   import psimd_pkg::*;

   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   req_type in_data_ff;
   rsp_type out_data_ff, exec_rsp;
   logic    out_load, in_load;

   psimd_exec u_exec (.req(in_data_ff), .rsp(exec_rsp));

   assign out_load     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_load      = req.valid && req.ready;
   assign req.ready    = !in_valid_ff || out_load;
   assign out_valid_in = out_load || (out_valid_ff && !rsp.ready);
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign rsp.valid    = out_valid_ff;
   assign rsp.data     = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_load) begin
         in_data_ff <= req.data;
      end
      if (out_load) begin
         out_data_ff <= exec_rsp;
      end
   end
endmodule

// ----- sv/psimd_exec.sv -----
// combinational execute logic: one request in, one response out
module psimd_exec (
   input  psimd_pkg::req_type req,
   output psimd_pkg::rsp_type rsp
);
   import psimd_pkg::*;

   logic [127:0] d, s, r, lw, sh;
   logic [15:0]  msk;
   logic         zf, cf, ok;
   logic [7:0]   db [16];
   logic [7:0]   sbt [16];
   logic [4:0]   bcnt;
   op_type       op;

   assign d  = {req.dest_high, req.dest_low};
   assign s  = {req.source_high, req.source_low};
   assign op = op_type'(req.action);
   assign bcnt = (req.immediate > 8'd16) ? 5'd16 : req.immediate[4:0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         db[i]  = d[8*i +: 8];
         sbt[i] = s[8*i +: 8];
      end
   end

   // lane arithmetic and compares
   always_comb begin
      lw = '0;
      case (op)
         OP_PCMPEQB: for (int i = 0; i < 16; i++) lw[8*i +: 8] = {8{d[8*i +: 8] == s[8*i +: 8]}};
         OP_PCMPEQW: for (int i = 0; i < 8; i++) lw[16*i +: 16] = {16{d[16*i +: 16] == s[16*i +: 16]}};
         OP_PCMPEQD: for (int i = 0; i < 4; i++) lw[32*i +: 32] = {32{d[32*i +: 32] == s[32*i +: 32]}};
         OP_PCMPEQQ: for (int i = 0; i < 2; i++) lw[64*i +: 64] = {64{d[64*i +: 64] == s[64*i +: 64]}};
         OP_PCMPGTB: for (int i = 0; i < 16; i++)
            lw[8*i +: 8] = {8{$signed(d[8*i +: 8]) > $signed(s[8*i +: 8])}};
         OP_PCMPGTW: for (int i = 0; i < 8; i++)
            lw[16*i +: 16] = {16{$signed(d[16*i +: 16]) > $signed(s[16*i +: 16])}};
         OP_PCMPGTD: for (int i = 0; i < 4; i++)
            lw[32*i +: 32] = {32{$signed(d[32*i +: 32]) > $signed(s[32*i +: 32])}};
         OP_PMINUB: for (int i = 0; i < 16; i++)
            lw[8*i +: 8] = (d[8*i +: 8] < s[8*i +: 8]) ? d[8*i +: 8] : s[8*i +: 8];
         OP_PMAXUB: for (int i = 0; i < 16; i++)
            lw[8*i +: 8] = (d[8*i +: 8] > s[8*i +: 8]) ? d[8*i +: 8] : s[8*i +: 8];
         OP_PADDB: for (int i = 0; i < 16; i++) lw[8*i +: 8] = d[8*i +: 8] + s[8*i +: 8];
         OP_PADDW: for (int i = 0; i < 8; i++) lw[16*i +: 16] = d[16*i +: 16] + s[16*i +: 16];
         OP_PADDD: for (int i = 0; i < 4; i++) lw[32*i +: 32] = d[32*i +: 32] + s[32*i +: 32];
         OP_PADDQ: for (int i = 0; i < 2; i++) lw[64*i +: 64] = d[64*i +: 64] + s[64*i +: 64];
         OP_PSUBB: for (int i = 0; i < 16; i++) lw[8*i +: 8] = d[8*i +: 8] - s[8*i +: 8];
         OP_PSUBW: for (int i = 0; i < 8; i++) lw[16*i +: 16] = d[16*i +: 16] - s[16*i +: 16];
         OP_PSUBD: for (int i = 0; i < 4; i++) lw[32*i +: 32] = d[32*i +: 32] - s[32*i +: 32];
         OP_PSUBQ: for (int i = 0; i < 2; i++) lw[64*i +: 64] = d[64*i +: 64] - s[64*i +: 64];
         default: lw = '0;
      endcase
   end

   // bit and byte shifts of the destination
   always_comb begin
      sh = '0;
      case (op)
         OP_PSRLW: for (int i = 0; i < 8; i++)
            sh[16*i +: 16] = (req.immediate >= 8'd16) ? '0 : d[16*i +: 16] >> req.immediate[3:0];
         OP_PSLLW: for (int i = 0; i < 8; i++)
            sh[16*i +: 16] = (req.immediate >= 8'd16) ? '0 : d[16*i +: 16] << req.immediate[3:0];
         OP_PSRAW: for (int i = 0; i < 8; i++)
            sh[16*i +: 16] = $signed(d[16*i +: 16]) >>>
               ((req.immediate >= 8'd16) ? 4'd15 : req.immediate[3:0]);
         OP_PSRLD: for (int i = 0; i < 4; i++)
            sh[32*i +: 32] = (req.immediate >= 8'd32) ? '0 : d[32*i +: 32] >> req.immediate[4:0];
         OP_PSLLD: for (int i = 0; i < 4; i++)
            sh[32*i +: 32] = (req.immediate >= 8'd32) ? '0 : d[32*i +: 32] << req.immediate[4:0];
         OP_PSRAD: for (int i = 0; i < 4; i++)
            sh[32*i +: 32] = $signed(d[32*i +: 32]) >>>
               ((req.immediate >= 8'd32) ? 5'd31 : req.immediate[4:0]);
         OP_PSRLQ: for (int i = 0; i < 2; i++)
            sh[64*i +: 64] = (req.immediate >= 8'd64) ? '0 : d[64*i +: 64] >> req.immediate[5:0];
         OP_PSLLQ: for (int i = 0; i < 2; i++)
            sh[64*i +: 64] = (req.immediate >= 8'd64) ? '0 : d[64*i +: 64] << req.immediate[5:0];
         OP_PSLLDQ: sh = d << {bcnt, 3'b000};
         OP_PSRLDQ: sh = d >> {bcnt, 3'b000};
         default: sh = '0;
      endcase
   end

   always_comb begin
      r   = '0;
      msk = '0;
      zf  = 1'b0;
      cf  = 1'b0;
      ok  = 1'b1;
      case (op)
         OP_AND:  r = d & s;
         OP_ANDN: r = ~d & s;
         OP_OR:   r = d | s;
         OP_XOR:  r = d ^ s;
         OP_PSHUFB: for (int i = 0; i < 16; i++)
            r[8*i +: 8] = sbt[i][7] ? 8'h00 : db[sbt[i][3:0]];
         OP_PTEST: begin
            r  = d;
            zf = ~|(d & s);
            cf = ~|(~d & s);
         end
         OP_PCMPEQB, OP_PCMPEQW, OP_PCMPEQD, OP_PCMPEQQ, OP_PCMPGTB, OP_PCMPGTW,
         OP_PCMPGTD, OP_PMINUB, OP_PMAXUB, OP_PADDB, OP_PADDW, OP_PADDD, OP_PADDQ,
         OP_PSUBB, OP_PSUBW, OP_PSUBD, OP_PSUBQ: r = lw;
         OP_PUNPCKLBW: for (int i = 0; i < 8; i++) r[16*i +: 16] = {s[8*i +: 8], d[8*i +: 8]};
         OP_PUNPCKLWD: for (int i = 0; i < 4; i++) r[32*i +: 32] = {s[16*i +: 16], d[16*i +: 16]};
         OP_PUNPCKLDQ, OP_UNPCKLPS: r = {s[63:32], d[63:32], s[31:0], d[31:0]};
         OP_PUNPCKLQDQ, OP_UNPCKLPD: r = {s[63:0], d[63:0]};
         OP_PUNPCKHQDQ: r = {s[127:64], d[127:64]};
         OP_PSHUFD: for (int i = 0; i < 4; i++)
            r[32*i +: 32] = s[32*req.immediate[2*i +: 2] +: 32];
         OP_PSHUFLW: begin
            r[127:64] = s[127:64];
            for (int i = 0; i < 4; i++) r[16*i +: 16] = s[16*req.immediate[2*i +: 2] +: 16];
         end
         OP_PSHUFHW: begin
            r[63:0] = s[63:0];
            for (int i = 0; i < 4; i++)
               r[64 + 16*i +: 16] = s[64 + 16*req.immediate[2*i +: 2] +: 16];
         end
         OP_SHUFPS: begin
            r[31:0]   = d[32*req.immediate[1:0] +: 32];
            r[63:32]  = d[32*req.immediate[3:2] +: 32];
            r[95:64]  = s[32*req.immediate[5:4] +: 32];
            r[127:96] = s[32*req.immediate[7:6] +: 32];
         end
         OP_SHUFPD: begin
            r[63:0]   = req.immediate[0] ? d[127:64] : d[63:0];
            r[127:64] = req.immediate[1] ? s[127:64] : s[63:0];
         end
         OP_PSRLW, OP_PSRAW, OP_PSLLW, OP_PSRLD, OP_PSRAD, OP_PSLLD, OP_PSRLQ, OP_PSLLQ,
         OP_PSLLDQ, OP_PSRLDQ: r = sh;
         OP_PMOVMSKB: for (int i = 0; i < 16; i++) msk[i] = s[8*i + 7];
         OP_MOVMSKPS: msk = {12'd0, s[127], s[95], s[63], s[31]};
         OP_MOVMSKPD: msk = {14'd0, s[127], s[63]};
         default: ok = 1'b0;
      endcase
   end

   assign rsp = '{result_low: r[63:0], result_high: r[127:64], sign_mask: msk,
                  zero_flag: zf, carry_flag: cf, supported: ok};
endmodule
